/* rtl/dmxsd_pkg.sv */
// shared types, codes and constants of the dmx strobe dimmer
`timescale 1ns / 1ps
`default_nettype none
package dmxsd_pkg;

	// width of the time counters and default queue depths
	localparam int TIME_WIDTH_DEF = 17;
	localparam int CMD_DEPTH_DEF  = 2;
	localparam int RES_DEPTH_DEF  = 2;

	localparam logic [7:0] LEVEL_MAX = 8'd255;

	// item op codes
	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_WRITE = 3'd1;
	localparam logic [2:0] OP_START = 3'd2;
	localparam logic [2:0] OP_STOP  = 3'd3;
	localparam logic [2:0] OP_FLIP  = 3'd4;

	// configuration register indexes
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_ADDR_W-1:0] REG_BASE_CHANNEL      = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_PULSE_MS          = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_MULTIPLIER = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_HIGH       = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_SILENCE_TIMEOUT   = 3'd4;

	// register reset values
	localparam logic [7:0]  BASE_CHANNEL_RST      = 8'd1;
	localparam logic [15:0] PULSE_MS_RST          = 16'd50;
	localparam logic [7:0]  PERIOD_MULTIPLIER_RST = 8'd10;
	localparam logic        ACTIVE_HIGH_RST       = 1'b1;
	localparam logic [15:0] SILENCE_TIMEOUT_RST   = 16'd5000;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] dmx_channel;
		logic [7:0] dmx_data;
	} in_item_t;

	typedef struct packed {
		logic [7:0] drive_level;
		logic       lit;
		logic       running;
	} out_item_t;

	// classified command handed from front to back
	typedef enum logic [2:0] {
		CMD_NONE   = 3'd0,
		CMD_TICK   = 3'd1,
		CMD_DIM    = 3'd2,
		CMD_STROBE = 3'd3,
		CMD_START  = 3'd4,
		CMD_STOP   = 3'd5,
		CMD_FLIP   = 3'd6
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	// configuration seen by the back end
	typedef struct packed {
		logic [15:0] pulse_ms;
		logic [7:0]  period_multiplier;
		logic        active_high;
		logic [15:0] silence_timeout_ms;
	} cfg_t;

endpackage
`default_nettype wire

/* rtl/dmxsd_fifo.sv */
// small synchronous queue with registered storage
`timescale 1ns / 1ps
`default_nettype none
module dmxsd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output      logic             full,
	input  wire logic             pop,
	output      logic [WIDTH-1:0] rdata,
	output      logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/dmxsd_front.sv */
// front end: accepts items and classifies them into commands
`timescale 1ns / 1ps
`default_nettype none
module dmxsd_front (
	input  wire logic               push,
	input  wire dmxsd_pkg::in_item_t in_item,
	output      logic               full,
	input  wire logic [7:0]         base_channel,
	output      logic               cmd_push,
	output      dmxsd_pkg::cmd_t    cmd,
	input  wire logic               cmd_full
);
	import dmxsd_pkg::*;

	logic is_dim, is_strobe;

	assign full     = cmd_full;
	assign cmd_push = push;

	// strobe slot sits one below the dimmer slot, none when base is zero
	assign is_dim    = (in_item.dmx_channel == base_channel);
	assign is_strobe = (base_channel != 8'd0) && (in_item.dmx_channel == base_channel - 8'd1);

	always_comb begin
		cmd.data = in_item.dmx_data;
		unique case (in_item.op)
			OP_TICK:  cmd.kind = CMD_TICK;
			OP_WRITE: begin
				if (is_dim) begin
					cmd.kind = CMD_DIM;
				end else if (is_strobe) begin
					cmd.kind = CMD_STROBE;
				end else begin
					cmd.kind = CMD_NONE;
				end
			end
			OP_START: cmd.kind = CMD_START;
			OP_STOP:  cmd.kind = CMD_STOP;
			OP_FLIP:  cmd.kind = CMD_FLIP;
			default:  cmd.kind = CMD_NONE;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/dmxsd_back.sv */
// back end: lamp state, strobe timing, silence timeout and drive level
`timescale 1ns / 1ps
`default_nettype none
module dmxsd_back #(
	parameter int TIME_WIDTH = dmxsd_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dmxsd_pkg::cfg_t      cfg,
	input  wire dmxsd_pkg::cmd_t      cmd,
	input  wire logic                 cmd_empty,
	output      logic                 cmd_pop,
	input  wire logic                 res_full,
	output      logic                 res_push,
	output      dmxsd_pkg::out_item_t res
);
	import dmxsd_pkg::*;

	localparam int TW = TIME_WIDTH;

	logic [7:0]    level_q, level_d;
	logic          lit_q, lit_d;
	logic          enabled_q, enabled_d;
	logic [TW-1:0] phase_elapsed_q, phase_elapsed_d;
	logic [TW-1:0] phase_length_q, phase_length_d;
	logic [TW-1:0] flash_period_q, flash_period_d;
	logic          armed_q, armed_d;
	logic [TW-1:0] silence_elapsed_q, silence_elapsed_d;

	logic [TW-1:0] pe_inc, se_inc, pulse_ext, timeout_ext;
	logic [15:0]   product;
	logic          exec;

	assign exec     = !cmd_empty && !res_full;
	assign cmd_pop  = exec;
	assign res_push = exec;

	assign pe_inc      = (phase_elapsed_q == '1) ? phase_elapsed_q : phase_elapsed_q + 1'b1;
	assign se_inc      = (silence_elapsed_q == '1) ? silence_elapsed_q : silence_elapsed_q + 1'b1;
	assign pulse_ext   = TW'(cfg.pulse_ms);
	assign timeout_ext = TW'(cfg.silence_timeout_ms);
	assign product     = 16'(cmd.data) * 16'(cfg.period_multiplier);

	always_comb begin
		level_d           = level_q;
		lit_d             = lit_q;
		enabled_d         = enabled_q;
		phase_elapsed_d   = phase_elapsed_q;
		phase_length_d    = phase_length_q;
		flash_period_d    = flash_period_q;
		armed_d           = armed_q;
		silence_elapsed_d = silence_elapsed_q;
		unique case (cmd.kind)
			CMD_TICK: begin
				phase_elapsed_d   = pe_inc;
				silence_elapsed_d = se_inc;
				if (enabled_q) begin
					if (armed_q && (se_inc > timeout_ext)) begin
						level_d           = 8'd0;
						silence_elapsed_d = '0;
					end else if (flash_period_q <= pulse_ext) begin
						phase_elapsed_d = '0;
						lit_d           = 1'b1;
					end else if (pe_inc >= phase_length_q) begin
						phase_elapsed_d = '0;
						lit_d           = !lit_q;
						// period exceeds pulse here, so the dark length is positive
						phase_length_d  = lit_q ? (flash_period_q - pulse_ext) : pulse_ext;
					end
				end
			end
			CMD_DIM:    level_d = cmd.data;
			CMD_STROBE: flash_period_d = TW'(product);
			CMD_START: begin
				if (!enabled_q) begin
					phase_length_d    = '0;
					lit_d             = 1'b1;
					enabled_d         = 1'b1;
					armed_d           = 1'b1;
					silence_elapsed_d = '0;
				end
			end
			CMD_STOP:   enabled_d = 1'b0;
			CMD_FLIP:   enabled_d = !enabled_q;
			default: begin
			end
		endcase
	end

	// drive level from the updated state
	always_comb begin
		res.lit     = lit_d;
		res.running = enabled_d;
		if (enabled_d && lit_d) begin
			res.drive_level = cfg.active_high ? level_d : LEVEL_MAX - level_d;
		end else begin
			res.drive_level = cfg.active_high ? 8'd0 : LEVEL_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q           <= '0;
			lit_q             <= 1'b1;
			enabled_q         <= 1'b1;
			phase_elapsed_q   <= '0;
			phase_length_q    <= '0;
			flash_period_q    <= '0;
			armed_q           <= 1'b0;
			silence_elapsed_q <= '0;
		end else if (exec) begin
			level_q           <= level_d;
			lit_q             <= lit_d;
			enabled_q         <= enabled_d;
			phase_elapsed_q   <= phase_elapsed_d;
			phase_length_q    <= phase_length_d;
			flash_period_q    <= flash_period_d;
			armed_q           <= armed_d;
			silence_elapsed_q <= silence_elapsed_d;
		end
	end
endmodule
`default_nettype wire

/* rtl/dmx_strobe_dimmer_top.sv */
// top level of the dmx strobe dimmer channel
// an item is held in the command queue, then its result in the result queue feeding the result ports
// throughput: one item per cycle while the result queue has room, set by the back end state update
// a command queue decouples classification from execution, a result queue holds outputs
// reset (arst_n low, asynchronous) empties both queues, loads register defaults
// and restores the lamp state: level zero, lit, enabled, timers cleared, timeout not armed
`timescale 1ns / 1ps
`default_nettype none
module dmx_strobe_dimmer_top #(
	parameter int TIME_WIDTH = dmxsd_pkg::TIME_WIDTH_DEF,
	parameter int CMD_DEPTH  = dmxsd_pkg::CMD_DEPTH_DEF,
	parameter int RES_DEPTH  = dmxsd_pkg::RES_DEPTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// item input side
	input  wire logic                                 push,
	output      logic                                 full,
	input  wire dmxsd_pkg::in_item_t                  in_item,
	// result side
	output      logic                                 empty,
	input  wire logic                                 pop,
	output      dmxsd_pkg::out_item_t                 out_item,
	// configuration write port
	input  wire logic                                 cfg_we,
	input  wire logic [dmxsd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  wire logic [dmxsd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import dmxsd_pkg::*;

	// configuration registers
	logic [7:0] base_channel_q;
	cfg_t       cfg_q;

	// front to command queue
	logic cmd_push, cmd_full;
	cmd_t cmd_in;
	// command queue to back
	logic cmd_pop, cmd_empty;
	cmd_t cmd_out;
	// back to result queue
	logic      res_push, res_full;
	out_item_t res_in;

	// register writes land at once; the user must write them only while the block is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_channel_q           <= BASE_CHANNEL_RST;
			cfg_q.pulse_ms           <= PULSE_MS_RST;
			cfg_q.period_multiplier  <= PERIOD_MULTIPLIER_RST;
			cfg_q.active_high        <= ACTIVE_HIGH_RST;
			cfg_q.silence_timeout_ms <= SILENCE_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_BASE_CHANNEL:      base_channel_q           <= cfg_wdata[7:0];
				REG_PULSE_MS:          cfg_q.pulse_ms           <= cfg_wdata[15:0];
				REG_PERIOD_MULTIPLIER: cfg_q.period_multiplier  <= cfg_wdata[7:0];
				REG_ACTIVE_HIGH:       cfg_q.active_high        <= cfg_wdata[0];
				REG_SILENCE_TIMEOUT:   cfg_q.silence_timeout_ms <= cfg_wdata[15:0];
				default: begin
					// writes beyond the register list are dropped
				end
			endcase
		end
	end

	// front: decode op and slot into a command
	dmxsd_front u_front (
		.push         (push),
		.in_item      (in_item),
		.full         (full),
		.base_channel (base_channel_q),
		.cmd_push     (cmd_push),
		.cmd          (cmd_in),
		.cmd_full     (cmd_full)
	);

	// command queue between front and back
	dmxsd_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	// back: one command per cycle whenever the result queue has room
	dmxsd_back #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// result queue, also the output register
	dmxsd_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (out_item),
		.empty  (empty)
	);
endmodule
`default_nettype wire

/* rtl/dmxsd_checker.sv */
// port-level checker for the dmx strobe dimmer and its bind
`timescale 1ns / 1ps
`default_nettype none
module dmxsd_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 push,
	input wire logic                 full,
	input wire logic                 empty,
	input wire logic                 pop,
	input wire dmxsd_pkg::out_item_t out_item
);
	import dmxsd_pkg::*;

	// coming out of reset the result queue is empty and the command queue is not full
	a_reset_state: assert property (@(posedge clk) $rose(arst_n) |-> empty && !full)
		else $error("queues not empty after reset");

	// an item taken while no result waits shows a result once it has passed the command queue and the result queue
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && empty |=> ##1 !empty)
		else $error("result missing after accepted item");

	// a waiting result holds while not taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_item))
		else $error("waiting result changed");

	// a dark or stopped lamp is driven fully off
	a_dark_level: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (!out_item.lit || !out_item.running)
		|-> (out_item.drive_level == 8'd0) || (out_item.drive_level == LEVEL_MAX))
		else $error("dark lamp with partial drive level");
endmodule

bind dmx_strobe_dimmer_top dmxsd_checker u_dmxsd_checker (.*);
`default_nettype wire
